>>> hw/rtl/signed_int64_to_decimal_ascii_assert.svh
// assertion macros for the signed 64-bit to decimal ascii block
// used by the top level only, needs a clock and an active-low reset name
`ifndef SIGNED_INT64_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT64_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked outside reset
`define I64DEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i64dec assertion failed");

// next-cycle implication, checked outside reset
`define I64DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i64dec assertion failed");

`endif

>>> hw/rtl/i64dec_pkg.sv
// shared constants and types for the signed 64-bit to decimal ascii block
// no dependencies
`default_nettype none

package i64dec_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 19;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = 5;
  localparam int unsigned BitCntWidth = 6;
  localparam int unsigned CharWidth  = 7;

  localparam logic [CharWidth-1:0] DigitBase = 7'd48;
  localparam logic [CharWidth-1:0] MinusCode = 7'd45;

  // status of the binary to bcd converter
  typedef struct packed {
    logic busy;
    logic done;
  } dab_sts_t;

  // control from the sequencer to the character emitter
  typedef struct packed {
    logic start;
    logic negative;
  } emit_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/i64dec_dabble.sv
// bit-serial binary to bcd converter (shift and add-3), one bit per cycle
// depends on i64dec_pkg
`default_nettype none

module i64dec_dabble (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [i64dec_pkg::ValueWidth-1:0]  mag_i,
  output i64dec_pkg::dab_sts_t                    sts_o,
  output logic [i64dec_pkg::BcdWidth-1:0]         bcd_o
);

  logic [i64dec_pkg::ValueWidth-1:0]  bin_q, bin_d;
  logic [i64dec_pkg::BcdWidth-1:0]    bcd_q, bcd_d;
  logic [i64dec_pkg::BcdWidth-1:0]    adj;
  logic [i64dec_pkg::BitCntWidth-1:0] cnt_q, cnt_d;
  logic                               busy_q, busy_d;
  logic                               done_q, done_d;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < i64dec_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bin_d = {bin_q[i64dec_pkg::ValueWidth-2:0], 1'b0};
      bcd_d = {adj[i64dec_pkg::BcdWidth-2:0], bin_q[i64dec_pkg::ValueWidth-1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign bcd_o      = bcd_q;

endmodule

`default_nettype wire

>>> hw/rtl/i64dec_emit.sv
// character emitter: skips leading zero digits, sends sign and digits
// through a registered output stage; depends on i64dec_pkg
`default_nettype none

module i64dec_emit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire i64dec_pkg::emit_ctl_t              ctl_i,
  input  wire logic [i64dec_pkg::BcdWidth-1:0]    bcd_i,
  output logic                                    busy_o,
  output logic                                    tvalid_o,
  input  wire logic                               tready_i,
  output logic [i64dec_pkg::CharWidth-1:0]        char_o,
  output logic                                    tlast_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSkip = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic [i64dec_pkg::BcdWidth-1:0]    bcd_q, bcd_d;
  logic [i64dec_pkg::CntWidth-1:0]    cnt_q, cnt_d;
  logic                               neg_q, neg_d;
  logic                               tvalid_q, tvalid_d;
  logic [i64dec_pkg::CharWidth-1:0]   char_q, char_d;
  logic                               tlast_q, tlast_d;
  logic [3:0]                         top_digit;
  logic                               slot_free;

  assign top_digit = bcd_q[i64dec_pkg::BcdWidth-1 -: 4];
  assign slot_free = !tvalid_q || tready_i;

  always_comb begin
    state_d  = state_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    tvalid_d = tvalid_q && !tready_i;
    char_d   = char_q;
    tlast_d  = tlast_q;
    case (state_q)
      StIdle: begin
        if (ctl_i.start) begin
          bcd_d   = bcd_i;
          cnt_d   = i64dec_pkg::CntWidth'(i64dec_pkg::NumDigits);
          neg_d   = ctl_i.negative;
          state_d = StSkip;
        end
      end
      StSkip: begin
        // drop leading zeros, always keep the final digit
        if (top_digit == 4'd0 && cnt_q != 5'd1) begin
          bcd_d = {bcd_q[i64dec_pkg::BcdWidth-5:0], 4'd0};
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = StSend;
        end
      end
      StSend: begin
        if (slot_free) begin
          tvalid_d = 1'b1;
          if (neg_q) begin
            char_d  = i64dec_pkg::MinusCode;
            tlast_d = 1'b0;
            neg_d   = 1'b0;
          end else begin
            char_d  = i64dec_pkg::DigitBase + {3'd0, top_digit};
            tlast_d = (cnt_q == 5'd1);
            bcd_d   = {bcd_q[i64dec_pkg::BcdWidth-5:0], 4'd0};
            cnt_d   = cnt_q - 1'b1;
            if (cnt_q == 5'd1) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      tvalid_q <= 1'b0;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      tvalid_q <= tvalid_d;
      cnt_q    <= cnt_d;
      neg_q    <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q   <= bcd_d;
    char_q  <= char_d;
    tlast_q <= tlast_d;
  end

  assign busy_o   = (state_q != StIdle);
  assign tvalid_o = tvalid_q;
  assign char_o   = char_q;
  assign tlast_o  = tlast_q;

endmodule

`default_nettype wire

>>> hw/rtl/signed_int64_to_decimal_ascii.sv
// signed 64-bit integer to decimal ascii text, top level
// depends on i64dec_pkg, i64dec_dabble, i64dec_emit and the assertion header
//
// usage:
//   slave stream: s_axis_tdata_i carries one signed 64-bit value per transfer.
//   master stream: one ascii character per transfer, most significant first,
//   a leading '-' for negative values, m_axis_tlast_o on the final digit.
//   a run is 1 to 20 transfers; zero gives a single '0'.
// throughput:
//   one value at a time. the input transfer loads a bit-serial double-dabble
//   converter that shifts in all 64 bits; its registered done flag hands the
//   digits to the emitter, which drops leading zeros one digit per cycle (up
//   to 18), moves to its send state, then loads one character per cycle
//   while the receiver keeps up. skipped zeros plus digits always make 19.
//   s_axis_tready_o rises once the sequencer sees the emitter idle after
//   the last character is loaded into the output register, so the next
//   conversion overlaps the final transfer.
// reset:
//   rst_ni clears the sequencer, converter and output valid; no run survives.
// stall:
//   a low m_axis_tready_i holds the output register and the emitter waits;
//   nothing is dropped or repeated.
`default_nettype none

module signed_int64_to_decimal_ascii (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side, tdata bits [63:0]: value
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,
  // master side, tdata bits [6:0]: character, bit [7]: zero fill
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  `include "signed_int64_to_decimal_ascii_assert.svh"

  // sequencer codes
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic                                neg_q, neg_d;
  logic                                in_xfer;
  logic [i64dec_pkg::ValueWidth-1:0]   mag;
  logic [i64dec_pkg::BcdWidth-1:0]     bcd;
  i64dec_pkg::dab_sts_t                dab_sts;
  i64dec_pkg::emit_ctl_t               emit_ctl;
  logic                                emit_busy;
  logic [i64dec_pkg::CharWidth-1:0]    out_char;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // magnitude as unsigned; the most negative value maps to 2^63
  assign mag = s_axis_tdata_i[63] ? (~s_axis_tdata_i + 64'd1) : s_axis_tdata_i;

  // start the emitter the cycle the converter reports done
  assign emit_ctl.start    = (state_q == StConv) && dab_sts.done;
  assign emit_ctl.negative = neg_q;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          neg_d   = s_axis_tdata_i[63];
          state_d = StConv;
        end
      end
      StConv: begin
        if (dab_sts.done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // free once the final character has been loaded for output
        if (!emit_busy) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  i64dec_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .mag_i   (mag),
    .sts_o   (dab_sts),
    .bcd_o   (bcd)
  );

  i64dec_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (emit_ctl),
    .bcd_i    (bcd),
    .busy_o   (emit_busy),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .char_o   (out_char),
    .tlast_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

  // the converter only finishes while the sequencer waits for it
  `I64DEC_ASSERT_NOW(a_done_in_conv, clk_i, rst_ni, dab_sts.done, state_q == StConv)
  // an accepted value starts the converter on the next cycle
  `I64DEC_ASSERT_NEXT(a_xfer_starts_conv, clk_i, rst_ni, in_xfer, dab_sts.busy)
  // the minus sign never ends a run
  `I64DEC_ASSERT_NOW(a_minus_not_last, clk_i, rst_ni,
    m_axis_tvalid_o && (out_char == i64dec_pkg::MinusCode), !m_axis_tlast_o)
  // a run always ends on a decimal digit
  `I64DEC_ASSERT_NOW(a_last_is_digit, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o,
    (out_char >= i64dec_pkg::DigitBase) && (out_char <= i64dec_pkg::DigitBase + 7'd9))

endmodule

`default_nettype wire
